@@ rtl/wbd_pkg.sv @@
// shared types, class codes and break rules of the word boundary detector
package wbd_pkg;

    localparam int CLASS_BITS = 5;
    localparam int OUT_POS_BITS = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef logic [CLASS_BITS-1:0] wb_class_t;

    localparam wb_class_t C_OTHER     = 5'd0;
    localparam wb_class_t C_CR        = 5'd1;
    localparam wb_class_t C_LF        = 5'd2;
    localparam wb_class_t C_NEWLINE   = 5'd3;
    localparam wb_class_t C_EXTEND    = 5'd4;
    localparam wb_class_t C_FORMAT    = 5'd5;
    localparam wb_class_t C_ZWJ       = 5'd6;
    localparam wb_class_t C_RI        = 5'd7;
    localparam wb_class_t C_KATAKANA  = 5'd8;
    localparam wb_class_t C_HEBREW    = 5'd9;
    localparam wb_class_t C_ALETTER   = 5'd10;
    localparam wb_class_t C_SQUOTE    = 5'd11;
    localparam wb_class_t C_DQUOTE    = 5'd12;
    localparam wb_class_t C_MIDNUMLET = 5'd13;
    localparam wb_class_t C_MIDLETTER = 5'd14;
    localparam wb_class_t C_MIDNUM    = 5'd15;
    localparam wb_class_t C_NUMERIC   = 5'd16;
    localparam wb_class_t C_EXTNUMLET = 5'd17;
    localparam wb_class_t C_WSEG      = 5'd18;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_NONE    = 2'd0;
    localparam kind_t KIND_AH      = 2'd1;
    localparam kind_t KIND_HEBREW  = 2'd2;
    localparam kind_t KIND_NUMERIC = 2'd3;

    typedef enum logic [1:0] {
        DEC_KEEP  = 2'd0,
        DEC_BREAK = 2'd1,
        DEC_HOLD  = 2'd2
    } dec_t;

    typedef struct packed {
        dec_t  dec;
        kind_t kind;
    } verdict_t;

    // one queue entry: the one or two results caused by an item
    typedef struct packed {
        logic [OUT_POS_BITS-1:0] first_pos;
        logic                    first_brk;
        logic                    two;
        logic [OUT_POS_BITS-1:0] second_pos;
        logic                    second_brk;
    } job_t;

    function automatic logic is_ign(wb_class_t c);
        return c == C_EXTEND || c == C_FORMAT || c == C_ZWJ;
    endfunction

    function automatic logic is_nl(wb_class_t c);
        return c == C_CR || c == C_LF || c == C_NEWLINE;
    endfunction

    function automatic logic is_ah(wb_class_t c);
        return c == C_ALETTER || c == C_HEBREW;
    endfunction

    function automatic logic is_midl(wb_class_t c);
        return c == C_MIDLETTER || c == C_MIDNUMLET || c == C_SQUOTE;
    endfunction

    function automatic logic is_midn(wb_class_t c);
        return c == C_MIDNUM || c == C_MIDNUMLET || c == C_SQUOTE;
    endfunction

    function automatic logic is_ahnk(wb_class_t c);
        return is_ah(c) || c == C_NUMERIC || c == C_KATAKANA;
    endfunction

    function automatic logic kind_matches(kind_t k, wb_class_t c);
        logic m;
        case (k)
            KIND_AH:      m = is_ah(c);
            KIND_HEBREW:  m = (c == C_HEBREW);
            KIND_NUMERIC: m = (c == C_NUMERIC);
            default:      m = 1'b0;
        endcase
        return m;
    endfunction

    // rules wb3 to wb16 and wb999 on the current context
    function automatic verdict_t decide(wb_class_t raw, wb_class_t l, wb_class_t bl_in,
                                        logic [1:0] seen, logic ri_odd,
                                        wb_class_t r, logic ep);
        verdict_t  v;
        wb_class_t bl;
        v.kind = KIND_NONE;
        v.dec  = DEC_BREAK;
        bl = (seen >= 2'd2) ? bl_in : C_OTHER;
        if (seen == 2'd0 && raw == C_OTHER) return v;
        v.dec = DEC_KEEP;
        if (raw == C_CR && r == C_LF) return v;
        v.dec = DEC_BREAK;
        if (is_nl(raw) || is_nl(r)) return v;
        v.dec = DEC_KEEP;
        if (raw == C_ZWJ && ep) return v;
        if (raw == C_WSEG && r == C_WSEG) return v;
        if (is_ign(r)) return v;
        v.dec = DEC_BREAK;
        if (seen == 2'd0) return v;
        v.dec = DEC_KEEP;
        if (is_ah(l) && is_ah(r)) return v;
        if (is_ah(l) && is_midl(r)) v.kind = KIND_AH;
        if (is_ah(r) && is_midl(l) && is_ah(bl)) return v;
        if (l == C_HEBREW && r == C_SQUOTE) return v;
        if (l == C_HEBREW && r == C_DQUOTE) v.kind = KIND_HEBREW;
        if (r == C_HEBREW && l == C_DQUOTE && bl == C_HEBREW) return v;
        if (l == C_NUMERIC && r == C_NUMERIC) return v;
        if (is_ah(l) && r == C_NUMERIC) return v;
        if (l == C_NUMERIC && is_ah(r)) return v;
        if (r == C_NUMERIC && is_midn(l) && bl == C_NUMERIC) return v;
        if (l == C_NUMERIC && is_midn(r)) v.kind = KIND_NUMERIC;
        if (l == C_KATAKANA && r == C_KATAKANA) return v;
        if ((is_ahnk(l) || l == C_EXTNUMLET) && r == C_EXTNUMLET) return v;
        if (l == C_EXTNUMLET && is_ahnk(r)) return v;
        if (l == C_RI && r == C_RI && ri_odd) return v;
        v.dec = (v.kind != KIND_NONE) ? DEC_HOLD : DEC_BREAK;
        return v;
    endfunction

endpackage

@@ rtl/wbd_front.sv @@
// front part: accepts items, applies the break rules and builds queue entries
module wbd_front #(
    parameter int POS_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                acc,
    input  wbd_pkg::wb_class_t  wb_class,
    input  logic                ext_pict,
    input  logic                end_of_text,
    output logic                push,
    output wbd_pkg::job_t       job
);
    import wbd_pkg::*;

    wb_class_t             prev_class_reg, prev_class_next;
    wb_class_t             sig_left_class_reg, sig_left_class_next;
    wb_class_t             sig_before_left_class_reg, sig_before_left_class_next;
    logic [1:0]            sig_seen_reg, sig_seen_next;
    logic                  ri_odd_reg, ri_odd_next;
    logic [POS_BITS-1:0]   char_index_reg, char_index_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [POS_BITS-1:0]   pend_index_reg, pend_index_next;
    kind_t                 pend_kind_reg, pend_kind_next;

    wb_class_t c;
    verdict_t  v;
    logic      resolve;
    logic      held;
    logic      pend_brk;

    // out-of-range classes count as other
    assign c = (wb_class > C_WSEG) ? C_OTHER : wb_class;
    assign v = decide(prev_class_reg, sig_left_class_reg, sig_before_left_class_reg,
                      sig_seen_reg, ri_odd_reg, c, ext_pict);
    assign resolve  = !is_ign(c) && pend_valid_reg;
    assign held     = (v.dec == DEC_HOLD);
    assign pend_brk = !kind_matches(pend_kind_reg, c);

    always_comb
    begin
        prev_class_next            = prev_class_reg;
        sig_left_class_next        = sig_left_class_reg;
        sig_before_left_class_next = sig_before_left_class_reg;
        sig_seen_next              = sig_seen_reg;
        ri_odd_next                = ri_odd_reg;
        char_index_next            = char_index_reg;
        pend_valid_next            = pend_valid_reg;
        pend_index_next            = pend_index_reg;
        pend_kind_next             = pend_kind_reg;
        push                       = 1'b0;
        job.first_pos              = OUT_POS_BITS'(char_index_reg);
        job.first_brk              = 1'b1;
        job.two                    = 1'b0;
        job.second_pos             = OUT_POS_BITS'(char_index_reg);
        job.second_brk             = 1'b1;

        if (acc)
        begin
            if (end_of_text)
            begin
                push = 1'b1;
                if (pend_valid_reg)
                begin
                    job.first_pos = OUT_POS_BITS'(pend_index_reg);
                    job.two       = 1'b1;
                end
                prev_class_next            = C_OTHER;
                sig_left_class_next        = C_OTHER;
                sig_before_left_class_next = C_OTHER;
                sig_seen_next              = 2'd0;
                ri_odd_next                = 1'b0;
                char_index_next            = '0;
                pend_valid_next            = 1'b0;
                pend_index_next            = '0;
                pend_kind_next             = KIND_NONE;
            end
            else
            begin
                push = resolve || !held;
                if (resolve)
                begin
                    job.first_pos   = OUT_POS_BITS'(pend_index_reg);
                    job.first_brk   = pend_brk;
                    job.two         = !held;
                    job.second_brk  = (v.dec == DEC_BREAK);
                    pend_valid_next = 1'b0;
                    pend_kind_next  = KIND_NONE;
                end
                else
                begin
                    job.first_brk = (v.dec == DEC_BREAK);
                end
                if (held)
                begin
                    pend_valid_next = 1'b1;
                    pend_index_next = char_index_reg;
                    pend_kind_next  = v.kind;
                end
                prev_class_next = c;
                if (!is_ign(c))
                begin
                    sig_before_left_class_next = sig_left_class_reg;
                    sig_left_class_next        = c;
                    if (sig_seen_reg != 2'd2)
                        sig_seen_next = sig_seen_reg + 2'd1;
                    ri_odd_next = (c == C_RI) ? !ri_odd_reg : 1'b0;
                end
                char_index_next = char_index_reg + POS_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_class_reg            <= C_OTHER;
            sig_left_class_reg        <= C_OTHER;
            sig_before_left_class_reg <= C_OTHER;
            sig_seen_reg              <= 2'd0;
            ri_odd_reg                <= 1'b0;
            char_index_reg            <= '0;
            pend_valid_reg            <= 1'b0;
            pend_index_reg            <= '0;
            pend_kind_reg             <= KIND_NONE;
        end
        else
        begin
            prev_class_reg            <= prev_class_next;
            sig_left_class_reg        <= sig_left_class_next;
            sig_before_left_class_reg <= sig_before_left_class_next;
            sig_seen_reg              <= sig_seen_next;
            ri_odd_reg                <= ri_odd_next;
            char_index_reg            <= char_index_next;
            pend_valid_reg            <= pend_valid_next;
            pend_index_reg            <= pend_index_next;
            pend_kind_reg             <= pend_kind_next;
        end
    end

    a_pend_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> pend_kind_reg != KIND_NONE)
        else $error("held boundary without an awaited class");

    a_seen_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        sig_seen_reg != 2'd3)
        else $error("significant count past saturation");

    a_eot_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        acc && end_of_text |=> char_index_reg == '0 && !pend_valid_reg)
        else $error("context not cleared after end of text");

    a_hold_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        acc && !end_of_text && held && !resolve |-> !push)
        else $error("held item pushed a result of its own");

endmodule

@@ rtl/wbd_queue.sv @@
// short queue of result entries between the front and back parts
module wbd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  wbd_pkg::job_t  push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output wbd_pkg::job_t  head_job
);
    import wbd_pkg::*;

    job_t                      mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg, count_next;

    assign full       = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CNT_BITS'(push) - QUEUE_CNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

@@ rtl/wbd_back.sv @@
// back part: turns queue entries into one or two result items
module wbd_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                head_valid,
    input  wbd_pkg::job_t                       head_job,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [wbd_pkg::OUT_POS_BITS-1:0]    position,
    output logic                                boundary,
    output logic                                last
);
    import wbd_pkg::*;

    logic                    out_valid_reg, out_valid_next;
    logic [OUT_POS_BITS-1:0] out_pos_reg, out_pos_next;
    logic                    out_brk_reg, out_brk_next;
    logic                    out_last_reg, out_last_next;
    logic                    hold_valid_reg, hold_valid_next;
    logic [OUT_POS_BITS-1:0] hold_pos_reg, hold_pos_next;
    logic                    hold_brk_reg, hold_brk_next;
    logic                    advance;

    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && !hold_valid_reg && head_valid;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_pos_next    = out_pos_reg;
        out_brk_next    = out_brk_reg;
        out_last_next   = out_last_reg;
        hold_valid_next = hold_valid_reg;
        hold_pos_next   = hold_pos_reg;
        hold_brk_next   = hold_brk_reg;
        if (advance)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_pos_next    = hold_pos_reg;
                out_brk_next    = hold_brk_reg;
                out_last_next   = 1'b1;
                hold_valid_next = 1'b0;
            end
            else if (head_valid)
            begin
                out_valid_next  = 1'b1;
                out_pos_next    = head_job.first_pos;
                out_brk_next    = head_job.first_brk;
                out_last_next   = !head_job.two;
                hold_valid_next = head_job.two;
                hold_pos_next   = head_job.second_pos;
                hold_brk_next   = head_job.second_brk;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pos_reg   <= out_pos_next;
        out_brk_reg   <= out_brk_next;
        out_last_reg  <= out_last_next;
        hold_pos_reg  <= hold_pos_next;
        hold_brk_reg  <= hold_brk_next;
    end

    assign out_valid = out_valid_reg;
    assign position  = out_pos_reg;
    assign boundary  = out_brk_reg;
    assign last      = out_last_reg;

    a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> out_valid_reg && !out_last_reg)
        else $error("second result held with no first result shown");

    a_not_last_has_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_last_reg |-> hold_valid_reg)
        else $error("result not marked last but nothing follows");

    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg)
        else $error("popped entry not shown");

endmodule

@@ rtl/word_boundary_detector.sv @@
// top level of the streaming word boundary detector
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   wb_class, ext_pict, end_of_text
//  out      output     out_valid / out_stall position, boundary, last
//
// one item accepted per cycle while the queue is not full; the rules are evaluated in the cycle of acceptance
// results pass through the queue and the output register, one result per cycle on the output while out_stall is low
// an end-of-text item that flushes a held boundary, or an item that resolves a held boundary and is not
// held itself, gives two results, so the output can fall behind; a four-entry queue absorbs the difference
// in_stall rises only when the queue is full; out_stall backs up into the queue
// reset clears the context, the queue and the output register at once
module word_boundary_detector #(
    parameter int POS_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [wbd_pkg::CLASS_BITS-1:0]    wb_class,
    input  logic                              ext_pict,
    input  logic                              end_of_text,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [wbd_pkg::OUT_POS_BITS-1:0]  position,
    output logic                              boundary,
    output logic                              last
);
    import wbd_pkg::*;

    logic acc;
    logic push;
    job_t push_job;
    logic full;
    logic pop;
    logic head_valid;
    job_t head_job;

    assign in_stall = full;
    assign acc      = in_valid && !full;

    wbd_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .acc         (acc),
        .wb_class    (wb_class),
        .ext_pict    (ext_pict),
        .end_of_text (end_of_text),
        .push        (push),
        .job         (push_job)
    );

    wbd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    wbd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .position   (position),
        .boundary   (boundary),
        .last       (last)
    );

endmodule

@@ tb/word_boundary_detector_tb.sv @@
// self-checking testbench for the streaming word boundary detector
`timescale 1ns / 100ps

module testbench;
    import wbd_pkg::*;

    typedef struct packed {
        logic [OUT_POS_BITS-1:0] pos;
        logic                    brk;
        logic                    lst;
    } boundary_t;

    // tracks the text context and holds the boundaries still owed by the block
    class boundary_scoreboard;
        boundary_t               due_boundaries[$];
        int                      errors;
        wb_class_t               prev_class;
        wb_class_t               sig_left;
        wb_class_t               sig_prev;
        int unsigned             sig_count;
        bit                      ri_parity;
        bit [OUT_POS_BITS-1:0]   next_pos;
        bit                      held;
        bit [OUT_POS_BITS-1:0]   held_pos;
        kind_t                   held_kind;

        function new();
            errors = 0;
            clear_context();
        endfunction

        function void clear_context();
            prev_class = C_OTHER;
            sig_left   = C_OTHER;
            sig_prev   = C_OTHER;
            sig_count  = 0;
            ri_parity  = 1'b0;
            next_pos   = '0;
            held       = 1'b0;
            held_pos   = '0;
            held_kind  = KIND_NONE;
        endfunction

        function bit transparent(wb_class_t c);
            return c == C_EXTEND || c == C_FORMAT || c == C_ZWJ;
        endfunction

        function bit line_end(wb_class_t c);
            return c == C_CR || c == C_LF || c == C_NEWLINE;
        endfunction

        function bit letter(wb_class_t c);
            return c == C_ALETTER || c == C_HEBREW;
        endfunction

        function bit letter_mid(wb_class_t c);
            return c == C_MIDLETTER || c == C_MIDNUMLET || c == C_SQUOTE;
        endfunction

        function bit number_mid(wb_class_t c);
            return c == C_MIDNUM || c == C_MIDNUMLET || c == C_SQUOTE;
        endfunction

        function bit word_like(wb_class_t c);
            return letter(c) || c == C_NUMERIC || c == C_KATAKANA;
        endfunction

        function bit awaited(kind_t k, wb_class_t c);
            if (k == KIND_AH)
                return letter(c);
            if (k == KIND_HEBREW)
                return c == C_HEBREW;
            if (k == KIND_NUMERIC)
                return c == C_NUMERIC;
            return 1'b0;
        endfunction

        // break decision before a code point of class r
        function dec_t rule_verdict(wb_class_t r, bit ep, output kind_t k);
            wb_class_t bl;
            k = KIND_NONE;
            if (sig_count == 0 && prev_class == C_OTHER)
                return DEC_BREAK;
            if (prev_class == C_CR && r == C_LF)
                return DEC_KEEP;
            if (line_end(prev_class) || line_end(r))
                return DEC_BREAK;
            if (prev_class == C_ZWJ && ep)
                return DEC_KEEP;
            if (prev_class == C_WSEG && r == C_WSEG)
                return DEC_KEEP;
            if (transparent(r))
                return DEC_KEEP;
            if (sig_count == 0)
                return DEC_BREAK;
            bl = (sig_count >= 2) ? sig_prev : C_OTHER;
            if (letter(sig_left) && letter(r))
                return DEC_KEEP;
            if (letter(sig_left) && letter_mid(r))
                k = KIND_AH;
            if (letter(r) && letter_mid(sig_left) && letter(bl))
                return DEC_KEEP;
            if (sig_left == C_HEBREW && r == C_SQUOTE)
                return DEC_KEEP;
            if (sig_left == C_HEBREW && r == C_DQUOTE)
                k = KIND_HEBREW;
            if (r == C_HEBREW && sig_left == C_DQUOTE && bl == C_HEBREW)
                return DEC_KEEP;
            if (sig_left == C_NUMERIC && r == C_NUMERIC)
                return DEC_KEEP;
            if (letter(sig_left) && r == C_NUMERIC)
                return DEC_KEEP;
            if (sig_left == C_NUMERIC && letter(r))
                return DEC_KEEP;
            if (r == C_NUMERIC && number_mid(sig_left) && bl == C_NUMERIC)
                return DEC_KEEP;
            if (sig_left == C_NUMERIC && number_mid(r))
                k = KIND_NUMERIC;
            if (sig_left == C_KATAKANA && r == C_KATAKANA)
                return DEC_KEEP;
            if ((word_like(sig_left) || sig_left == C_EXTNUMLET) && r == C_EXTNUMLET)
                return DEC_KEEP;
            if (sig_left == C_EXTNUMLET && word_like(r))
                return DEC_KEEP;
            if (sig_left == C_RI && r == C_RI && ri_parity)
                return DEC_KEEP;
            return (k != KIND_NONE) ? DEC_HOLD : DEC_BREAK;
        endfunction

        function void note_item(wb_class_t cls_in, bit ep, bit eot);
            boundary_t fresh[$];
            boundary_t b;
            wb_class_t c;
            kind_t     k;
            dec_t      d;
            c = (cls_in > C_WSEG) ? C_OTHER : cls_in;
            b.lst = 1'b0;
            if (eot) begin
                if (held) begin
                    b.pos = held_pos;
                    b.brk = 1'b1;
                    fresh.push_back(b);
                end
                b.pos = next_pos;
                b.brk = 1'b1;
                fresh.push_back(b);
                clear_context();
            end
            else begin
                // a significant class settles the held boundary first
                if (!transparent(c) && held) begin
                    b.pos = held_pos;
                    b.brk = !awaited(held_kind, c);
                    fresh.push_back(b);
                    held      = 1'b0;
                    held_kind = KIND_NONE;
                end
                d = rule_verdict(c, ep, k);
                if (d == DEC_HOLD) begin
                    held      = 1'b1;
                    held_pos  = next_pos;
                    held_kind = k;
                end
                else begin
                    b.pos = next_pos;
                    b.brk = (d == DEC_BREAK);
                    fresh.push_back(b);
                end
                prev_class = c;
                if (!transparent(c)) begin
                    sig_prev = sig_left;
                    sig_left = c;
                    if (sig_count < 2)
                        sig_count++;
                    ri_parity = (c == C_RI) ? !ri_parity : 1'b0;
                end
                next_pos++;
            end
            if (fresh.size() > 0)
                fresh[fresh.size() - 1].lst = 1'b1;
            foreach (fresh[i])
                due_boundaries.push_back(fresh[i]);
        endfunction

        function void check_result(logic [OUT_POS_BITS-1:0] pos, logic brk, logic lst);
            boundary_t e;
            if (due_boundaries.size() == 0) begin
                $error("unexpected result: position %0d boundary %b last %b", pos, brk, lst);
                errors++;
                return;
            end
            e = due_boundaries.pop_front();
            if (pos !== e.pos) begin
                $error("position: expected %0d, got %0d", e.pos, pos);
                errors++;
            end
            if (brk !== e.brk) begin
                $error("boundary: expected %b, got %b", e.brk, brk);
                errors++;
            end
            if (lst !== e.lst) begin
                $error("last: expected %b, got %b", e.lst, lst);
                errors++;
            end
        endfunction

        function int outstanding();
            return due_boundaries.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [CLASS_BITS-1:0]   wb_class = '0;
    logic                    ext_pict = 1'b0;
    logic                    end_of_text = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [OUT_POS_BITS-1:0] position;
    logic                    boundary;
    logic                    last;

    boundary_scoreboard sb;
    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;

    word_boundary_detector u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .wb_class    (wb_class),
        .ext_pict    (ext_pict),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .position    (position),
        .boundary    (boundary),
        .last        (last)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(position, boundary, last);
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic send_item(wb_class_t cls, bit ep, bit eot);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        wb_class    <= cls;
        ext_pict    <= ep;
        end_of_text <= eot;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(cls, ep, eot);
        items_sent++;
    endtask

    function automatic wb_class_t pick_letter();
        return $urandom_range(0, 1) ? C_HEBREW : C_ALETTER;
    endfunction

    function automatic wb_class_t pick_letter_mid();
        case ($urandom_range(0, 2))
            0:       return C_MIDLETTER;
            1:       return C_MIDNUMLET;
            default: return C_SQUOTE;
        endcase
    endfunction

    function automatic wb_class_t pick_number_mid();
        case ($urandom_range(0, 2))
            0:       return C_MIDNUM;
            1:       return C_MIDNUMLET;
            default: return C_SQUOTE;
        endcase
    endfunction

    function automatic wb_class_t pick_transparent();
        case ($urandom_range(0, 2))
            0:       return C_EXTEND;
            1:       return C_FORMAT;
            default: return C_ZWJ;
        endcase
    endfunction

    function automatic wb_class_t pick_word_part();
        case ($urandom_range(0, 3))
            0:       return C_KATAKANA;
            1:       return C_EXTNUMLET;
            2:       return C_NUMERIC;
            default: return C_ALETTER;
        endcase
    endfunction

    function automatic wb_class_t any_class();
        return wb_class_t'($urandom_range(0, C_WSEG));
    endfunction

    // one code point, now and then followed by an extend, format or zwj
    task automatic send_class(wb_class_t c);
        send_item(c, $urandom_range(0, 7) == 0, 1'b0);
        if ($urandom_range(0, 4) == 0)
            send_item(pick_transparent(), $urandom_range(0, 7) == 0, 1'b0);
    endtask

    task automatic send_fragment();
        int len;
        len = $urandom_range(1, 4);
        case ($urandom_range(0, 11))
            0:
                repeat (len) send_class(pick_letter());
            1:
            begin
                send_class(pick_letter());
                send_class(pick_letter_mid());
                send_class($urandom_range(0, 9) < 7 ? pick_letter() : any_class());
            end
            2:
            begin
                send_class(C_HEBREW);
                send_class($urandom_range(0, 3) == 0 ? C_SQUOTE : C_DQUOTE);
                send_class($urandom_range(0, 9) < 7 ? C_HEBREW : any_class());
            end
            3:
            begin
                send_class(C_NUMERIC);
                send_class(pick_number_mid());
                send_class($urandom_range(0, 9) < 7 ? C_NUMERIC : any_class());
            end
            4:
                repeat (len) send_class(pick_word_part());
            5:
                repeat (len + $urandom_range(0, 1)) send_class(C_RI);
            6:
            begin
                send_item(C_CR, 1'b0, 1'b0);
                send_item($urandom_range(0, 9) < 6 ? C_LF : C_NEWLINE, 1'b0, 1'b0);
            end
            7:
                repeat (len) send_item(C_WSEG, $urandom_range(0, 7) == 0, 1'b0);
            8:
            begin
                send_item(C_ZWJ, 1'($urandom_range(0, 1)), 1'b0);
                send_item(any_class(), 1'b1, 1'b0);
            end
            9, 10:
                repeat (len) send_item(wb_class_t'($urandom_range(0, 31)),
                                       1'($urandom_range(0, 1)), 1'b0);
            default:
                send_class(any_class());
        endcase
    endtask

    task automatic run_text(int count, int eot_pct);
        int start;
        start = items_sent;
        while (items_sent - start < count)
        begin
            send_fragment();
            if ($urandom_range(0, 99) < eot_pct)
                send_item(wb_class_t'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                          1'b1);
        end
    endtask

    task automatic run_directed();
        send_item(C_ALETTER, 1'b0, 1'b0);       // start of text
        send_item(C_SQUOTE, 1'b0, 1'b0);        // held until the next letter
        send_item(C_EXTEND, 1'b0, 1'b0);
        send_item(C_ALETTER, 1'b0, 1'b0);
        send_item(C_MIDNUMLET, 1'b0, 1'b0);
        send_item(C_OTHER, 1'b0, 1'b1);         // end of text flushes the held boundary
        send_item(C_OTHER, 1'b0, 1'b1);         // empty text
        send_item(C_HEBREW, 1'b0, 1'b0);
        send_item(C_DQUOTE, 1'b0, 1'b0);
        send_item(C_HEBREW, 1'b0, 1'b0);
        send_item(C_DQUOTE, 1'b0, 1'b0);
        send_item(C_NUMERIC, 1'b0, 1'b0);       // held boundary turns into a break
        send_item(C_MIDNUM, 1'b0, 1'b0);
        send_item(C_NUMERIC, 1'b0, 1'b0);
        send_item(C_CR, 1'b0, 1'b0);
        send_item(C_LF, 1'b0, 1'b0);
        send_item(C_NEWLINE, 1'b0, 1'b0);
        send_item(C_ZWJ, 1'b0, 1'b0);
        send_item(C_OTHER, 1'b1, 1'b0);
        send_item(C_RI, 1'b0, 1'b0);
        send_item(C_RI, 1'b0, 1'b0);
        send_item(C_RI, 1'b0, 1'b0);
        send_item(C_WSEG, 1'b0, 1'b0);
        send_item(C_WSEG, 1'b0, 1'b0);
        send_item('1, 1'b1, 1'b0);              // class code beyond the table
        send_item('1, 1'b1, 1'b1);
    endtask

    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_text(120, 10);
        send_item(C_OTHER, 1'b0, 1'b1);

        idle_pct  = 87;
        stall_pct = 0;
        run_text(150, 10);
        idle_pct  = 0;
        stall_pct = 87;
        run_text(150, 10);
        idle_pct  = 13;
        stall_pct = 13;
        run_text(200, 10);

        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.errors == 0)
            $display("** word_boundary_detector: PASSED **");
        else
            $display("** word_boundary_detector: FAILED **");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("** word_boundary_detector: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/wbd_pkg.sv
rtl/wbd_front.sv
rtl/wbd_queue.sv
rtl/wbd_back.sv
rtl/word_boundary_detector.sv
tb/word_boundary_detector_tb.sv
